// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and sizes that the sorted priority queue modules share.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned ORDER_W = 16;
  localparam int unsigned COUNT_W = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One queue entry as a cell holds it.
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  prio;
    logic [ORDER_W-1:0] order;
  } entry_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, shifts toward the tail on an
// insert ahead of it and toward the head on a remove.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_i,     // neighbor nearer the head
  input  logic       left_gb_i,  // new item goes before the left neighbor
  input  entry_t     right_i,    // neighbor nearer the tail
  output entry_t     entry_o,
  output logic       gb_o        // new item goes at or before this slot
);

  entry_t entry_q, entry_d;

  // An empty slot always accepts; strict compare keeps equal keys in order.
  always_comb begin
    gb_o = !entry_q.valid
        || (ctrl_i.item.prio < entry_q.prio)
        || ((ctrl_i.item.prio == entry_q.prio) && (ctrl_i.item.order < entry_q.order));
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rem) begin
      entry_d = right_i;
    end else if (ctrl_i.ins && gb_o) begin
      entry_d = left_gb_i ? left_i : ctrl_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- design/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept in service order in a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries (tag, priority, arrival order), sorted so
// that the lowest priority number, then the lowest arrival order, sits in the
// head cell; equal keys leave first in, first out. An input word with tuser
// OP_INSERT places its entry; one with OP_REMOVE pops the head. Each word
// yields exactly one output word with a status, the removed entry (zeros for
// inserts, full and empty reports) and the count held afterward. Every cell
// compares the new entry with its own in parallel and all shift together, so
// an input word is taken every cycle while the output register drains; its
// registered result is valid in the cycle after. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // [31:0] job_tag, [39:32] priority_req,
                                       // [55:40] arrival_order
  input  logic [0:0]  s_axis_tuser_i,  // [0] operation
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // [31:0] out_job_tag, [39:32] out_priority,
                                       // [55:40] out_arrival_order,
                                       // [59:56] entry_count, [63:60] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  logic             in_acc;
  op_e              op;
  cell_ctrl_t       ctrl;
  entry_t           cell_entry [DEPTH];
  logic             cell_gb    [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;

  // output register
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [PRIO_W-1:0]  prio_q, prio_d;
  logic [ORDER_W-1:0] order_q, order_d;
  logic [COUNT_W-1:0] ecount_q, ecount_d;

  // Take a new word whenever the result slot is free or drains this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i[0]);
  assign full            = (count_q == CNT_W'(DEPTH));
  assign empty           = (count_q == '0);

  // Broadcast the command; a full insert or empty remove leaves the row alone.
  always_comb begin
    ctrl.ins        = in_acc && (op == OP_INSERT) && !full;
    ctrl.rem        = in_acc && (op == OP_REMOVE) && !empty;
    ctrl.item.valid = 1'b1;
    ctrl.item.tag   = s_axis_tdata_i[31:0];
    ctrl.item.prio  = s_axis_tdata_i[39:32];
    ctrl.item.order = s_axis_tdata_i[55:40];
  end

  // Cell 0 is the head; its left neighbor never takes the new entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gb;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_gb = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_entry[i-1];
      assign left_gb = cell_gb[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .left_i   (left_e),
      .left_gb_i(left_gb),
      .right_i  (right_e),
      .entry_o  (cell_entry[i]),
      .gb_o     (cell_gb[i])
    );
  end

  // Track the fill level alongside the row.
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Build the result word; entry fields stay zero unless the head is popped.
  always_comb begin
    status_d = ST_OK;
    tag_d    = '0;
    prio_d   = '0;
    order_d  = '0;
    ecount_d = COUNT_W'(count_d);
    if (op == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      tag_d   = cell_entry[0].tag;
      prio_d  = cell_entry[0].prio;
      order_d = cell_entry[0].order;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: load on every accepted word, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      prio_q   <= prio_d;
      order_q  <= order_d;
      ecount_q <= ecount_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, ecount_q, order_q, prio_q, tag_q};
  assign m_axis_tuser_o  = status_q;

endmodule

// ----- design/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue result stream.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_FULL)
                        || (m_axis_tuser_o == ST_EMPTY))
    else $error("spq: undefined status code");

  // Full and empty reports carry no entry.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> (m_axis_tdata_o[55:0] == '0))
    else $error("spq: entry fields set on a failed operation");

  // An empty report leaves nothing held.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY)) |-> (m_axis_tdata_o[59:56] == '0))
    else $error("spq: empty report with entries held");

  // A stalled result holds its word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("spq: stalled result changed");

  // Input is refused only while a result waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && !s_axis_tready_o) |-> m_axis_tvalid_o)
    else $error("spq: input stalled with no result pending");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
